// ===== sv/cmt_pkg.sv =====
// Shared types, constants and functions of the cylinder mesh tessellator.
package cmt_pkg;

   localparam int MaxSegments = 4096;
   localparam int CntW = 13;
   localparam int IdxW = 12;
   localparam int DivStages = 8;
   localparam int CordicSteps = 16;
   localparam int CordicStages = CordicSteps / 2;

   localparam logic signed [31:0] CORDIC_GAIN = 32'sd326016437;
   localparam logic signed [15:0] TRIG_MAX = 16'sd32767;

   // result kinds
   localparam logic [1:0] KIND_BOTTOM = 2'd0;
   localparam logic [1:0] KIND_TOP = 2'd1;
   localparam logic [1:0] KIND_TRI = 2'd2;
   localparam logic [1:0] KIND_ERR = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_COUNT = 2'd2;
   localparam logic [1:0] CSR_SWEEP = 2'd3;

   // per-item info that rides along the pipeline
   typedef struct packed {
      logic err;
      logic [IdxW-1:0] idx;
      logic [IdxW-1:0] nxt;
   } tag_type;

   // arctangent of 2^-k in 1/65536 turn
   function automatic logic signed [17:0] atan_turn(input int k);
      logic signed [17:0] v;
      unique case (k)
         0: v = 18'sd8192;
         1: v = 18'sd4836;
         2: v = 18'sd2555;
         3: v = 18'sd1297;
         4: v = 18'sd651;
         5: v = 18'sd326;
         6: v = 18'sd163;
         7: v = 18'sd81;
         8: v = 18'sd41;
         9: v = 18'sd20;
         10: v = 18'sd10;
         11: v = 18'sd5;
         12: v = 18'sd3;
         13: v = 18'sd1;
         14: v = 18'sd1;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/cmt_divider.sv =====
// Pipelined restoring divider: 16 quotient bits, two bits per stage.
module cmt_divider
   import cmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  logic [CntW-1:0] in_rem,
   input  logic [15:0] in_dvd,
   input  tag_type in_tag,
   input  logic [CntW-1:0] divisor,
   output logic out_vld,
   output logic [15:0] out_quo,
   output tag_type out_tag
);

   logic [DivStages-1:0] vld_ff;
   logic [CntW-1:0] rem_ff [DivStages];
   logic [15:0] dvd_ff [DivStages];
   logic [15:0] quo_ff [DivStages];
   tag_type tag_ff [DivStages];

   logic [CntW-1:0] rem_in [DivStages];
   logic [15:0] dvd_in [DivStages];
   logic [15:0] quo_in [DivStages];

   // two restoring steps per stage
   always_comb begin
      logic [CntW-1:0] r;
      logic [15:0] d;
      logic [15:0] q;
      logic [CntW:0] t;
      for (int s = 0; s < DivStages; s++) begin
         if (s == 0) begin
            r = in_rem;
            d = in_dvd;
            q = '0;
         end else begin
            r = rem_ff[s-1];
            d = dvd_ff[s-1];
            q = quo_ff[s-1];
         end
         for (int b = 0; b < 2; b++) begin
            t = {r, d[15]};
            d = {d[14:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
               t = t - {1'b0, divisor};
               q = {q[14:0], 1'b1};
            end else begin
               q = {q[14:0], 1'b0};
            end
            r = t[CntW-1:0];
         end
         rem_in[s] = r;
         dvd_in[s] = d;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DivStages-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int s = 0; s < DivStages; s++) begin
            rem_ff[s] <= rem_in[s];
            dvd_ff[s] <= dvd_in[s];
            quo_ff[s] <= quo_in[s];
         end
         for (int s = 1; s < DivStages; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign out_vld = vld_ff[DivStages-1];
   assign out_quo = quo_ff[DivStages-1];
   assign out_tag = tag_ff[DivStages-1];

endmodule

// ===== sv/cmt_cordic.sv =====
// Pipelined rotation CORDIC over the first quadrant, two iterations per stage.
module cmt_cordic
   import cmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  logic [15:0] in_theta,
   input  tag_type in_tag,
   output logic out_vld,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic [1:0] out_quad,
   output tag_type out_tag
);

   logic [CordicStages-1:0] vld_ff;
   logic signed [31:0] x_ff [CordicStages];
   logic signed [31:0] y_ff [CordicStages];
   logic signed [17:0] z_ff [CordicStages];
   logic [1:0] quad_ff [CordicStages];
   tag_type tag_ff [CordicStages];

   logic signed [31:0] x_in [CordicStages];
   logic signed [31:0] y_in [CordicStages];
   logic signed [17:0] z_in [CordicStages];

   // micro-rotations 2s and 2s+1 in stage s
   always_comb begin
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [17:0] z;
      for (int s = 0; s < CordicStages; s++) begin
         if (s == 0) begin
            x = CORDIC_GAIN;
            y = '0;
            z = {4'b0000, in_theta[13:0]};
         end else begin
            x = x_ff[s-1];
            y = y_ff[s-1];
            z = z_ff[s-1];
         end
         for (int b = 0; b < 2; b++) begin
            dx = y >>> (2 * s + b);
            dy = x >>> (2 * s + b);
            if (!z[17]) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_turn(2 * s + b);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_turn(2 * s + b);
            end
         end
         x_in[s] = x;
         y_in[s] = y;
         z_in[s] = z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[CordicStages-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quad_ff[0] <= in_theta[15:14];
         tag_ff[0] <= in_tag;
         for (int s = 0; s < CordicStages; s++) begin
            x_ff[s] <= x_in[s];
            y_ff[s] <= y_in[s];
            z_ff[s] <= z_in[s];
         end
         for (int s = 1; s < CordicStages; s++) begin
            quad_ff[s] <= quad_ff[s-1];
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign out_vld = vld_ff[CordicStages-1];
   assign out_x = x_ff[CordicStages-1];
   assign out_y = y_ff[CordicStages-1];
   assign out_quad = quad_ff[CordicStages-1];
   assign out_tag = tag_ff[CordicStages-1];

endmodule

// ===== sv/cmt_scale.sv =====
// Q1.15 rounding, quadrant mapping and radius scaling, three stages.
module cmt_scale
   import cmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic [1:0] in_quad,
   input  tag_type in_tag,
   input  logic [15:0] radius,
   output logic out_vld,
   output logic signed [16:0] out_x,
   output logic signed [16:0] out_z,
   output tag_type out_tag
);

   logic [2:0] vld_ff;
   tag_type tag1_ff, tag2_ff, tag3_ff;
   logic [14:0] magc_ff, mags_ff;
   logic negc_ff, negs_ff, negc2_ff, negs2_ff;
   logic [30:0] prodc_ff, prods_ff;
   logic signed [16:0] x_ff, z_ff;

   logic [14:0] magc_in, mags_in;
   logic negc_in, negs_in;
   logic signed [16:0] x_in, z_in;

   function automatic logic signed [15:0] to_q15(input logic signed [31:0] v);
      logic signed [31:0] r;
      logic signed [15:0] o;
      r = (v + 32'sd8192) >>> 14;
      if (r > 32'(TRIG_MAX)) o = TRIG_MAX;
      else if (r < -32'(TRIG_MAX)) o = -TRIG_MAX;
      else o = r[15:0];
      return o;
   endfunction

   function automatic logic signed [16:0] round_out(input logic [30:0] p, input logic neg);
      logic [31:0] t;
      logic signed [16:0] m;
      t = {1'b0, p} + 32'd16384;
      m = {1'b0, t[30:15]};
      return neg ? -m : m;
   endfunction

   // stage 1: round, saturate, map to quadrant, split into sign and magnitude
   always_comb begin
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic signed [15:0] qc;
      logic signed [15:0] qs;
      c = to_q15(in_x);
      s = to_q15(in_y);
      unique case (in_quad)
         2'd0: begin qc = c; qs = s; end
         2'd1: begin qc = -s; qs = c; end
         2'd2: begin qc = -c; qs = -s; end
         default: begin qc = s; qs = -c; end
      endcase
      negc_in = qc[15];
      negs_in = qs[15];
      magc_in = qc[15] ? 15'(-qc) : qc[14:0];
      mags_in = qs[15] ? 15'(-qs) : qs[14:0];
   end

   // stage 3: round half away from zero
   assign x_in = round_out(prodc_ff, negc2_ff);
   assign z_in = round_out(prods_ff, negs2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag1_ff <= in_tag;
         magc_ff <= magc_in;
         mags_ff <= mags_in;
         negc_ff <= negc_in;
         negs_ff <= negs_in;
         // stage 2: radius multiply
         tag2_ff <= tag1_ff;
         prodc_ff <= radius * magc_ff;
         prods_ff <= radius * mags_ff;
         negc2_ff <= negc_ff;
         negs2_ff <= negs_ff;
         tag3_ff <= tag2_ff;
         x_ff <= x_in;
         z_ff <= z_in;
      end
   end

   assign out_vld = vld_ff[2];
   assign out_x = x_ff;
   assign out_z = z_ff;
   assign out_tag = tag3_ff;

endmodule

// ===== sv/cylinder_mesh_tessellator_unit.sv =====
// Cylinder side tessellator: one segment index in, bottom/top vertex and two triangles out.
// Each accepted index passes a 21-stage pipeline (index check, sweep multiply, 8-stage
// divider, 8-stage CORDIC, 3-stage scaling) and then emits four results, one per cycle
// while rsp_stall is low, from an output holding register (one error result for an
// out-of-range index). The result channel sets the sustained rate: each in-range index
// holds the channel for its four results, an out-of-range index for only one.
// Configuration must be written only while the block is empty.
module cylinder_mesh_tessellator_unit
   import cmt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [IdxW-1:0] req_segment_index,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic signed [16:0] rsp_coord_x,
   output logic [15:0] rsp_coord_y,
   output logic signed [16:0] rsp_coord_z,
   output logic [CntW-1:0] rsp_corner_a,
   output logic [CntW-1:0] rsp_corner_b,
   output logic [CntW-1:0] rsp_corner_c,
   output logic rsp_last
);

   logic [15:0] radius_ff, height_ff, sweep_ff;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] n_eff;

   logic adv;
   logic a_vld_ff, b_vld_ff;
   tag_type a_tag_ff, b_tag_ff, a_tag_in;
   logic [28:0] prod_ff;
   logic [16:0] sweep_eff;

   logic div_vld;
   logic [15:0] div_quo;
   tag_type div_tag;
   logic cor_vld;
   logic signed [31:0] cor_x, cor_y;
   logic [1:0] cor_quad;
   tag_type cor_tag;
   logic sc_vld;
   logic signed [16:0] sc_x, sc_z;
   tag_type sc_tag;

   logic ser_vld_ff;
   logic [1:0] cnt_ff;
   tag_type ser_tag_ff;
   logic signed [16:0] ser_x_ff, ser_z_ff;
   logic ser_load, rsp_xfer;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         height_ff <= 16'd256;
         count_ff <= 13'd16;
         sweep_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_COUNT: count_ff <= csr_data[CntW-1:0];
            default: sweep_ff <= csr_data;
         endcase
      end
   end

   assign n_eff = (count_ff > CntW'(MaxSegments)) ? CntW'(MaxSegments) : count_ff;
   assign sweep_eff = (sweep_ff == '0) ? 17'h10000 : {1'b0, sweep_ff};

   // whole pipeline moves together; it stalls only when the tail cannot unload
   assign adv = !sc_vld || ser_load;
   assign req_stall = !adv;

   // stage A: range check and next meridian
   always_comb begin
      logic [CntW-1:0] ip1;
      ip1 = {1'b0, req_segment_index} + 13'd1;
      a_tag_in.idx = req_segment_index;
      a_tag_in.err = (n_eff == '0) || ({1'b0, req_segment_index} >= n_eff);
      a_tag_in.nxt = (ip1 == n_eff) ? '0 : ip1[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
      end
   end

   // stage B: index times sweep
   always_ff @(posedge clock) begin
      if (adv) begin
         a_tag_ff <= a_tag_in;
         b_tag_ff <= a_tag_ff;
         prod_ff <= a_tag_ff.idx * sweep_eff;
      end
   end

   cmt_divider u_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(b_vld_ff), .in_rem(prod_ff[28:16]), .in_dvd(prod_ff[15:0]),
      .in_tag(b_tag_ff), .divisor(n_eff),
      .out_vld(div_vld), .out_quo(div_quo), .out_tag(div_tag)
   );

   cmt_cordic u_cordic (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(div_vld), .in_theta(div_quo), .in_tag(div_tag),
      .out_vld(cor_vld), .out_x(cor_x), .out_y(cor_y), .out_quad(cor_quad),
      .out_tag(cor_tag)
   );

   cmt_scale u_scale (
      .clock(clock), .reset(reset), .en(adv),
      .in_vld(cor_vld), .in_x(cor_x), .in_y(cor_y), .in_quad(cor_quad),
      .in_tag(cor_tag), .radius(radius_ff),
      .out_vld(sc_vld), .out_x(sc_x), .out_z(sc_z), .out_tag(sc_tag)
   );

   // output holding register and result sequencing
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign ser_load = !ser_vld_ff || (rsp_xfer && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ser_load) begin
         ser_vld_ff <= sc_vld;
         cnt_ff <= '0;
      end else if (rsp_xfer) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_tag_ff <= sc_tag;
         ser_x_ff <= sc_x;
         ser_z_ff <= sc_z;
      end
   end

   always_comb begin
      logic vtx;
      logic tri_res;
      vtx = !ser_tag_ff.err && (cnt_ff == 2'd0 || cnt_ff == 2'd1);
      tri_res = !ser_tag_ff.err && !vtx;
      if (ser_tag_ff.err) rsp_kind = KIND_ERR;
      else if (cnt_ff == 2'd0) rsp_kind = KIND_BOTTOM;
      else if (cnt_ff == 2'd1) rsp_kind = KIND_TOP;
      else rsp_kind = KIND_TRI;
      rsp_coord_x = vtx ? ser_x_ff : '0;
      rsp_coord_z = vtx ? ser_z_ff : '0;
      rsp_coord_y = (vtx && cnt_ff == 2'd1) ? height_ff : '0;
      rsp_corner_a = tri_res ? {ser_tag_ff.idx, 1'b0} : '0;
      rsp_corner_b = !tri_res ? '0 :
                     (cnt_ff == 2'd2) ? {ser_tag_ff.idx, 1'b1} : {ser_tag_ff.nxt, 1'b0};
      rsp_corner_c = tri_res ? {ser_tag_ff.nxt, 1'b1} : '0;
      rsp_last = ser_tag_ff.err || (cnt_ff == 2'd3);
   end

   assign rsp_valid = ser_vld_ff;

endmodule
